FILE: hdl/rms_pkg.sv
// ----------------------------------------------------------------------------
// Randomized multiset package
// Shared types, codes and constants of the randomized multiset unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rms_pkg;

  // Store geometry.
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Sampling LFSR feedback taps.
  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

  // Operation codes.
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;

  // Status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // Input word.
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] item_value;
  } rms_in_t;

  // Result word.
  typedef struct packed {
    logic               success;
    logic signed [31:0] sampled_value;
    logic [1:0]         status;
    logic [8:0]         occupancy;
  } rms_out_t;

  // One step of the Galois LFSR.
  function automatic logic [31:0] lfsr_advance(input logic [31:0] s);
    logic [31:0] r;
    r = {1'b0, s[31:1]};
    if (s[0]) begin
      r = r ^ LFSR_TAPS;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/randomized_multiset_unit.sv
// ----------------------------------------------------------------------------
// Randomized multiset unit
// Bounded multiset of 32-bit values with insert, remove and random sample,
// built around one memory port pair and a small sequencer.
// ----------------------------------------------------------------------------
// Insert and remove scan the store one entry a cycle and stop at the first
// match; a remove that matches then moves the last entry into the hole.
// A sample runs a bit-serial modulo of the LFSR by the count. A full insert,
// an empty sample or the unused mode skips straight to the result. One word
// is in flight. Reset clears the count and loads the seed register and LFSR
// with 1; the store is not cleared, and no clearing pass runs after reset.
`default_nettype none

module randomized_multiset_unit (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Input channel
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire rms_pkg::rms_in_t in_data_i,
  // Output channel
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output rms_pkg::rms_out_t     out_data_o,
  // Configuration port
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  import rms_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_RM_RD   = 3'd2;
  localparam logic [2:0] ST_RM_WR   = 3'd3;
  localparam logic [2:0] ST_DIV     = 3'd4;
  localparam logic [2:0] ST_SMP_RD  = 3'd5;
  localparam logic [2:0] ST_SMP_DAT = 3'd6;
  localparam logic [2:0] ST_OUT     = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [1:0]        op_q, op_d;
  logic [31:0]       val_q, val_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [ADDR_W-1:0] cmp_idx_q, cmp_idx_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [31:0]       lfsr_q, lfsr_d;
  logic [31:0]       seed_q;
  logic [31:0]       dvd_q, dvd_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [4:0]        bit_q, bit_d;
  rms_out_t          res_q, res_d;
  logic              out_valid_q, out_valid_d;
  rms_out_t          out_data_q, out_data_d;

  // Value store and its port signals.
  logic [31:0]       mem [CAPACITY];
  logic [31:0]       rdata_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [31:0]       mem_wdata;
  logic [ADDR_W-1:0] rd_addr;

  logic              cfg_we;
  logic              accept;
  logic              match;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    trial_diff;
  logic [CNT_W-1:0]  cnt_last;

  // Configuration port: the seed register is decoded from paddr[2] alone, so it answers at word indices zero to three.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? seed_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= 32'd1;
    end else if (cfg_we) begin
      seed_q <= pwdata;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Datapath: equality compare for the scan, trial subtract for the modulo.
  assign match      = cmp_vld_q && (rdata_q == val_q);
  assign trial      = {rem_q, dvd_q[31]};
  assign trial_diff = trial - {1'b0, cnt_q};
  assign cnt_last   = cnt_q - CNT_W'(1);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    idx_d       = idx_q;
    cmp_vld_d   = cmp_vld_q;
    cmp_idx_d   = cmp_idx_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    lfsr_d      = lfsr_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q[ADDR_W-1:0];
    mem_wdata   = val_q;
    rd_addr     = idx_q[ADDR_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d      = in_data_i.mode;
          val_d     = in_data_i.item_value;
          idx_d     = '0;
          cmp_vld_d = 1'b0;
          res_d     = '{success: 1'b0, sampled_value: 32'sd0, status: STATUS_OK,
                        occupancy: 9'(cnt_q)};
          unique case (in_data_i.mode)
            MODE_INSERT: begin
              if (cnt_q == CNT_W'(CAPACITY)) begin
                res_d.status = STATUS_FULL;
                state_d      = ST_OUT;
              end else begin
                state_d = ST_SCAN;
              end
            end
            MODE_REMOVE: begin
              state_d = ST_SCAN;
            end
            MODE_SAMPLE: begin
              if (cnt_q == '0) begin
                res_d.status = STATUS_EMPTY;
                state_d      = ST_OUT;
              end else begin
                lfsr_d  = lfsr_advance(lfsr_q);
                dvd_d   = lfsr_advance(lfsr_q);
                rem_d   = '0;
                bit_d   = 5'd31;
                state_d = ST_DIV;
              end
            end
            default: begin
              state_d = ST_OUT;
            end
          endcase
        end
      end

      // One read issued and one compare done per cycle.
      ST_SCAN: begin
        if (match || (idx_q == cnt_q)) begin
          cmp_vld_d = 1'b0;
          if (op_q == MODE_INSERT) begin
            mem_we            = 1'b1;
            cnt_d             = cnt_q + CNT_W'(1);
            res_d.success     = !match;
            res_d.occupancy   = 9'(cnt_q + CNT_W'(1));
            state_d           = ST_OUT;
          end else if (match) begin
            pos_d   = cmp_idx_q;
            state_d = ST_RM_RD;
          end else begin
            state_d = ST_OUT;
          end
        end else begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q[ADDR_W-1:0];
          idx_d     = idx_q + CNT_W'(1);
        end
      end

      // Fetch the last entry to fill the hole.
      ST_RM_RD: begin
        rd_addr = cnt_last[ADDR_W-1:0];
        state_d = ST_RM_WR;
      end

      ST_RM_WR: begin
        mem_we          = 1'b1;
        mem_waddr       = pos_q;
        mem_wdata       = rdata_q;
        cnt_d           = cnt_last;
        res_d.success   = 1'b1;
        res_d.occupancy = 9'(cnt_last);
        state_d         = ST_OUT;
      end

      // Restoring modulo, one dividend bit per cycle.
      ST_DIV: begin
        if (trial >= {1'b0, cnt_q}) begin
          rem_d = trial_diff[CNT_W-1:0];
        end else begin
          rem_d = trial[CNT_W-1:0];
        end
        dvd_d = {dvd_q[30:0], 1'b0};
        bit_d = bit_q - 5'd1;
        if (bit_q == 5'd0) begin
          state_d = ST_SMP_RD;
        end
      end

      ST_SMP_RD: begin
        rd_addr = rem_q[ADDR_W-1:0];
        state_d = ST_SMP_DAT;
      end

      ST_SMP_DAT: begin
        res_d.success       = 1'b1;
        res_d.sampled_value = rdata_q;
        state_d             = ST_OUT;
      end

      // Hand the result to the output register once it is free.
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A seed write reloads the LFSR; zero is replaced by one.
    if (cfg_we) begin
      lfsr_d = (pwdata == 32'd0) ? 32'd1 : pwdata;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      lfsr_q      <= 32'd1;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      lfsr_q      <= lfsr_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    val_q      <= val_d;
    idx_q      <= idx_d;
    cmp_idx_q  <= cmp_idx_d;
    pos_q      <= pos_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    bit_q      <= bit_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  // Value store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[rd_addr];
  end

  // The count never exceeds the store capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // The count only changes at the end of an insert scan or a remove fill.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q == ST_SCAN || state_q == ST_RM_WR) |=> $stable(cnt_q))
    else $error("entry count changed outside an update");

  // The LFSR never locks up at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != 32'd0)
    else $error("sampling LFSR reached zero");

  // The partial remainder stays below the count during the modulo.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV || state_q == ST_SMP_RD) |-> (rem_q < cnt_q))
    else $error("modulo remainder out of range");

endmodule

`default_nettype wire

FILE: dv/randomized_multiset_unit_tb.sv
// ----------------------------------------------------------------------------
// Randomized multiset unit testbench
// Drives insert, remove, sample and unused-mode words through the input
// channel and checks every result word against a cycle-free shadow of the
// store, the count and the sampling LFSR. The seed register is written and
// read back through the APB port between phases, and the run covers a full
// store, a drained store, random mixes under sender gaps and receiver stalls,
// and one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module randomized_multiset_unit_tb;
  import rms_pkg::*;

  // Mode 3 has no operation behind it: the unit only reports its occupancy.
  localparam logic [1:0]  MODE_NONE       = 2'd3;
  localparam logic [2:0]  SEED_ADDR       = 3'd0;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES   = 300;
  localparam int unsigned QUIET_LIMIT     = 5000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  rms_in_t     in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  rms_out_t    out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the multiset state, advanced once per accepted word.
  logic [31:0] shadow_store [CAPACITY];
  int unsigned shadow_count;
  logic [31:0] shadow_lfsr;
  logic [31:0] shadow_seed;
  rms_out_t    pending_results [$];

  int unsigned error_count;
  int unsigned quiet_cycles;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_off_len;

  randomized_multiset_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Apply one word to the shadow state and return the result it must cause.
  function automatic rms_out_t predict_multiset_result(input rms_in_t w);
    rms_out_t    r;
    int unsigned pos;
    r = '0;
    pos = shadow_count;
    for (int unsigned i = 0; i < shadow_count; i++) begin
      if (pos == shadow_count && shadow_store[i] == w.item_value) begin
        pos = i;
      end
    end
    case (w.mode)
      MODE_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          r.success = (pos == shadow_count);
          shadow_store[shadow_count] = w.item_value;
          shadow_count++;
        end
      end
      MODE_REMOVE: begin
        // The last entry fills the hole left by the lowest occurrence.
        if (pos < shadow_count) begin
          shadow_store[pos] = shadow_store[shadow_count - 1];
          shadow_count--;
          r.success = 1'b1;
        end
      end
      MODE_SAMPLE: begin
        // An empty set leaves the LFSR where it is.
        if (shadow_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          shadow_lfsr = {1'b0, shadow_lfsr[31:1]} ^ (shadow_lfsr[0] ? LFSR_TAPS : 32'd0);
          r.sampled_value = shadow_store[shadow_lfsr % shadow_count];
          r.success = 1'b1;
        end
      end
      default: ;
    endcase
    r.occupancy = shadow_count[8:0];
    return r;
  endfunction

  // Values drawn mostly from a small pool so that duplicates and hits occur.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3, 4, 5: return $urandom_range(15);
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch in %s: got %0h, expected %0h, at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Offer one word, with random sender gaps, and predict it once accepted.
  task automatic send_word(input logic [1:0] op, input logic [31:0] value);
    rms_in_t w;
    w.mode = op;
    w.item_value = value;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(predict_multiset_result(w));
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Write the seed register while the unit is idle, then read it back.
  task automatic write_seed(input logic [31:0] seed);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SEED_ADDR;
    pwdata <= seed;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    shadow_seed = seed;
    shadow_lfsr = (seed == 32'd0) ? 32'd1 : seed;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== shadow_seed) begin
      report_mismatch("seed readback", 64'(prdata), 64'(shadow_seed));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Extremes, duplicates, absent removes, empty samples and the unused mode.
  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    send_word(MODE_SAMPLE, 32'd0);
    send_word(MODE_REMOVE, 32'd7);
    send_word(MODE_NONE, 32'hFFFF_FFFF);
    send_word(MODE_INSERT, 32'h8000_0000);
    send_word(MODE_INSERT, 32'h7FFF_FFFF);
    send_word(MODE_INSERT, 32'd0);
    send_word(MODE_INSERT, 32'hFFFF_FFFF);
    send_word(MODE_INSERT, 32'h8000_0000);
    send_word(MODE_SAMPLE, 32'hFFFF_FFFF);
    send_word(MODE_SAMPLE, 32'd0);
    send_word(MODE_REMOVE, 32'd5);
    send_word(MODE_REMOVE, 32'h8000_0000);
    send_word(MODE_REMOVE, 32'h7FFF_FFFF);
    send_word(MODE_NONE, 32'd0);
    send_word(MODE_REMOVE, 32'h8000_0000);
    send_word(MODE_REMOVE, 32'hFFFF_FFFF);
    send_word(MODE_REMOVE, 32'd0);
    send_word(MODE_SAMPLE, 32'd0);
    send_word(MODE_INSERT, 32'h5555_5555);
    send_word(MODE_INSERT, 32'hAAAA_AAAA);
    send_word(MODE_SAMPLE, 32'h5555_5555);
    send_word(MODE_REMOVE, 32'hAAAA_AAAA);
    send_word(MODE_REMOVE, 32'h5555_5555);
    wait_drained();
  endtask

  // Seed register extremes, including zero, which must start the LFSR at one.
  task automatic test_seed_register();
    idle_pct = 0;
    stall_pct = 0;
    send_word(MODE_INSERT, 32'd11);
    send_word(MODE_INSERT, 32'd22);
    send_word(MODE_INSERT, 32'd33);
    write_seed(32'hFFFF_FFFF);
    send_word(MODE_SAMPLE, 32'd0);
    send_word(MODE_SAMPLE, 32'd0);
    write_seed(32'd0);
    send_word(MODE_SAMPLE, 32'd0);
    send_word(MODE_SAMPLE, 32'd0);
    write_seed(32'h8000_0000);
    send_word(MODE_SAMPLE, 32'd0);
    write_seed($urandom());
    send_word(MODE_SAMPLE, 32'd0);
    send_word(MODE_SAMPLE, 32'd0);
    write_seed(32'd1);
  endtask

  // Fill the store to capacity and keep pushing at the full boundary.
  task automatic test_fill_and_overflow();
    idle_pct = 10;
    stall_pct = 10;
    while (shadow_count < CAPACITY) send_word(MODE_INSERT, pick_value());
    repeat (4) send_word(MODE_INSERT, pick_value());
    repeat (3) send_word(MODE_SAMPLE, $urandom());
    send_word(MODE_NONE, $urandom());
    send_word(MODE_REMOVE, shadow_store[$urandom_range(CAPACITY - 1)]);
    send_word(MODE_INSERT, pick_value());
    send_word(MODE_INSERT, pick_value());
    wait_drained();
  endtask

  // Remove stored values until the set is empty, sampling along the way.
  task automatic test_drain();
    idle_pct = 71;
    stall_pct = 0;
    while (shadow_count != 0) begin
      if ($urandom_range(7) == 0) begin
        send_word(MODE_SAMPLE, $urandom());
      end else begin
        send_word(MODE_REMOVE, shadow_store[$urandom_range(shadow_count - 1)]);
      end
    end
    send_word(MODE_SAMPLE, $urandom());
    send_word(MODE_REMOVE, pick_value());
    wait_drained();
  endtask

  // Random mix of operations; most removes name a value that is present.
  task automatic test_random_mix(input int unsigned words, input int unsigned idle,
                                 input int unsigned stall);
    int unsigned roll;
    idle_pct = idle;
    stall_pct = stall;
    repeat (words) begin
      roll = $urandom_range(99);
      if (roll < 45) begin
        send_word(MODE_INSERT, pick_value());
      end else if (roll < 72) begin
        if (shadow_count != 0 && roll < 65) begin
          send_word(MODE_REMOVE, shadow_store[$urandom_range(shadow_count - 1)]);
        end else begin
          send_word(MODE_REMOVE, pick_value());
        end
      end else if (roll < 96) begin
        send_word(MODE_SAMPLE, $urandom());
      end else begin
        send_word(MODE_NONE, $urandom());
      end
    end
    wait_drained();
  endtask

  // Hold the receiver off long enough that the unit stalls its input.
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_off_len = HOLD_OFF_CYCLES;
    repeat (24) begin
      if ($urandom_range(1) == 0) begin
        send_word(MODE_INSERT, pick_value());
      end else begin
        send_word(MODE_SAMPLE, $urandom());
      end
    end
    wait_drained();
  endtask

  // Receiver: random stalls, or one long hold-off when asked for.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_len != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_off_len) @(posedge clk_i);
        hold_off_len = 0;
      end
      out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    rms_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("word with no expectation", 64'(out_data_o), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.success !== want.success) begin
          report_mismatch("success", 64'(out_data_o.success), 64'(want.success));
        end
        if (out_data_o.sampled_value !== want.sampled_value) begin
          report_mismatch("sampled_value", 64'(out_data_o.sampled_value),
                          64'(want.sampled_value));
        end
        if (out_data_o.status !== want.status) begin
          report_mismatch("status", 64'(out_data_o.status), 64'(want.status));
        end
        if (out_data_o.occupancy !== want.occupancy) begin
          report_mismatch("occupancy", 64'(out_data_o.occupancy), 64'(want.occupancy));
        end
      end
    end
  end

  // Watchdog: end the run after too many cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    shadow_count = 0;
    shadow_seed = 32'd1;
    shadow_lfsr = 32'd1;
    error_count = 0;
    quiet_cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_off_len = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_seed_register();
    test_fill_and_overflow();
    test_drain();
    test_random_mix(75, 0, 0);
    test_random_mix(75, 71, 0);
    test_random_mix(75, 0, 71);
    test_random_mix(75, 10, 10);
    write_seed($urandom());
    test_random_mix(40, 0, 0);
    test_backpressure();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch("results never delivered", 64'(pending_results.size()), 64'd0);
    end
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/rms_pkg.sv
hdl/randomized_multiset_unit.sv
dv/randomized_multiset_unit_tb.sv
